[design/rgbfx_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and arithmetic helpers of the RGB LED effect sequencer.
package rgbfx_pkg;

  // Last step value; the step counter wraps to zero after it
  localparam logic [7:0] STEP_LAST = 8'd191;

  // Effect modes
  localparam logic [3:0] MODE_BLINK     = 4'd0;
  localparam logic [3:0] MODE_ALTERNATE = 4'd1;
  localparam logic [3:0] MODE_BREATHE   = 4'd2;
  localparam logic [3:0] MODE_FADE      = 4'd3;
  localparam logic [3:0] MODE_RAINBOW   = 4'd4;
  localparam logic [3:0] MODE_PULSE     = 4'd5;
  localparam logic [3:0] MODE_HEARTBEAT = 4'd6;
  localparam logic [3:0] MODE_SPARKLE   = 4'd7;
  localparam logic [3:0] MODE_CONFETTI  = 4'd8;

  // Configuration register indexes
  localparam logic [2:0] REG_MODE       = 3'd0;
  localparam logic [2:0] REG_PRIMARY    = 3'd1;
  localparam logic [2:0] REG_SECONDARY  = 3'd2;
  localparam logic [2:0] REG_BRIGHTNESS = 3'd3;
  localparam logic [2:0] REG_SEED       = 3'd4;

  // Reset values
  localparam logic [3:0]  RESET_MODE       = MODE_BREATHE;
  localparam logic [23:0] RESET_PRIMARY    = 24'hFFB450;
  localparam logic [23:0] RESET_SECONDARY  = 24'h0000FF;
  localparam logic [7:0]  RESET_BRIGHTNESS = 8'd13;
  localparam logic [31:0] RESET_SEED       = 32'd1;

  localparam logic [31:0] LFSR_TAPS = 32'h80200003;

  // Sparkle lights the pixel when the random value mod 100 is below this
  localparam logic [6:0] SPARKLE_CHANCE = 7'd35;

  typedef struct packed {
    logic [3:0]  mode;
    logic [23:0] primary;
    logic [23:0] secondary;
    logic [7:0]  brightness;
    logic [31:0] seed;
  } cfg_t;

  // One classified tick: its step and the random value it uses
  typedef struct packed {
    logic [7:0]  step;
    logic [31:0] noise;
  } tick_t;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  level;
    logic [23:0] remembered;
  } result_t;

  // Operations issued to the shared multiplier
  typedef enum logic [3:0] {
    OP_F0  = 4'd0,
    OP_F1  = 4'd1,
    OP_F2  = 4'd2,
    OP_F3  = 4'd3,
    OP_F4  = 4'd4,
    OP_F5  = 4'd5,
    OP_LVL = 4'd6,
    OP_S0  = 4'd7,
    OP_S1  = 4'd8,
    OP_S2  = 4'd9
  } op_t;

  // Galois LFSR, shifting right
  function automatic logic [31:0] lfsr_step(input logic [31:0] v);
    logic [31:0] n;
    n = {1'b0, v[31:1]};
    if (v[0]) begin
      n = n ^ LFSR_TAPS;
    end
    return n;
  endfunction

  // Exact floor(x / 255) for x below 65280
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] y;
    y = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
    return y[15:8];
  endfunction

  // Six-bit value mod 3: base-4 digits each weigh 1 mod 3
  function automatic logic [1:0] mod3_6(input logic [5:0] x);
    logic [3:0] r;
    r = {2'b00, x[1:0]} + {2'b00, x[3:2]} + {2'b00, x[5:4]};
    if (r >= 4'd6) begin
      r = r - 4'd6;
    end
    if (r >= 4'd3) begin
      r = r - 4'd3;
    end
    return r[1:0];
  endfunction

  // Fold one nibble, MSB first, into a running remainder mod 100
  function automatic logic [6:0] rem100_nibble(input logic [6:0] r, input logic [3:0] nib);
    logic [7:0] x;
    logic [6:0] acc;
    acc = r;
    for (int i = 3; i >= 0; i--) begin
      x = {acc, nib[i]};
      if (x >= 8'd100) begin
        x = x - 8'd100;
      end
      acc = x[6:0];
    end
    return acc;
  endfunction

  // Triangle wave over 64 steps, peak 248
  function automatic logic [7:0] triangle64(input logic [5:0] t);
    logic [4:0] u;
    u = t[5] ? ~t[4:0] : t[4:0];
    return {u, 3'b000};
  endfunction

  // Color wheel, packed red green blue
  function automatic logic [23:0] wheel(input logic [7:0] x);
    logic [7:0]  w;
    logic [7:0]  d;
    logic [8:0]  d3;
    logic [23:0] c;
    w = 8'd255 - x;
    if (w < 8'd85) begin
      d3 = {1'b0, w} + {w, 1'b0};
      c = {8'd255 - d3[7:0], 8'd0, d3[7:0]};
    end else if (w < 8'd170) begin
      d = w - 8'd85;
      d3 = {1'b0, d} + {d, 1'b0};
      c = {8'd0, d3[7:0], 8'd255 - d3[7:0]};
    end else begin
      d = w - 8'd170;
      d3 = {1'b0, d} + {d, 1'b0};
      c = {d3[7:0], 8'd255 - d3[7:0], 8'd0};
    end
    return c;
  endfunction

endpackage

[design/rgbfx_front.sv]
`timescale 1ns / 1ps
// Front end: accepts ticks, keeps the step counter and the LFSR, and queues each tick.
module rgbfx_front (
  input  logic               clk,
  input  logic               rst,
  input  rgbfx_pkg::cfg_t    cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               restart,
  output logic               push_valid,
  input  logic               push_ready,
  output rgbfx_pkg::tick_t   push_data
);

  logic [7:0]  step_count;
  logic [7:0]  step_count_next;
  logic [31:0] noise_register;
  logic [31:0] noise_register_next;
  logic [7:0]  step_now;
  logic [31:0] noise_now;
  logic        random_mode;

  // Apply restart, then step the LFSR for the random modes
  always_comb begin
    step_now    = restart ? 8'd0 : step_count;
    noise_now   = noise_register;
    if (restart) begin
      noise_now = (cfg.seed != 32'd0) ? cfg.seed : 32'd1;
    end
    random_mode = (cfg.mode == rgbfx_pkg::MODE_SPARKLE) ||
                  (cfg.mode == rgbfx_pkg::MODE_CONFETTI);
    noise_register_next = random_mode ? rgbfx_pkg::lfsr_step(noise_now) : noise_now;
    step_count_next = (step_now == rgbfx_pkg::STEP_LAST) ? 8'd0 : step_now + 8'd1;
  end

  assign in_ready        = push_ready;
  assign push_valid      = in_valid;
  assign push_data.step  = step_now;
  assign push_data.noise = noise_register_next;

  // Advance state on each accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      step_count     <= 8'd0;
      noise_register <= 32'd1;
    end else if (in_valid && push_ready) begin
      step_count     <= step_count_next;
      noise_register <= noise_register_next;
    end
  end

endmodule

[design/rgbfx_queue.sv]
`timescale 1ns / 1ps
// Two-entry queue of classified ticks between the front and back ends.
module rgbfx_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push_valid,
  output logic               push_ready,
  input  rgbfx_pkg::tick_t   push_data,
  output logic               pop_valid,
  input  logic               pop_ready,
  output rgbfx_pkg::tick_t   pop_data
);

  rgbfx_pkg::tick_t slot [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_data   = slot[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Store entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot[wr_ptr] <= push_data;
    end
  end

  // Move pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (do_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !do_push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

[design/rgbfx_back.sv]
`timescale 1ns / 1ps
// Back end: works out base color and level of a tick on one shared multiplier and holds the result.
module rgbfx_back (
  input  logic                clk,
  input  logic                rst,
  input  rgbfx_pkg::cfg_t     cfg,
  input  logic                pop_valid,
  output logic                pop_ready,
  input  rgbfx_pkg::tick_t    pop_data,
  output logic                out_valid,
  input  logic                out_ready,
  output rgbfx_pkg::result_t  result
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_REM   = 5'b00010,
    ST_SETUP = 5'b00100,
    ST_MUL   = 5'b01000,
    ST_WRITE = 5'b10000
  } state_t;

  state_t           state;
  logic [7:0]       step;
  logic [31:0]      rnd;
  logic [6:0]       rem;
  logic [2:0]       nib_cnt;
  logic [23:0]      color;
  logic [7:0]       level;
  logic [7:0]       lvl_arg;
  logic [15:0]      acc;
  logic [15:0]      prod;
  rgbfx_pkg::op_t   op;
  rgbfx_pkg::op_t   op_next;
  rgbfx_pkg::op_t   pend_op;
  logic             pend_valid;
  logic             issuing;
  logic [7:0]       res_r;
  logic [7:0]       res_g;
  logic [7:0]       res_b;
  logic [23:0]      last_lit;
  logic [23:0]      lit_next;

  logic [7:0]       v;
  logic [3:0]       t12;
  logic [7:0]       mul_a;
  logic [7:0]       mul_b;
  logic             issue_ok;
  logic [15:0]      mix_sum;
  logic [15:0]      round_sum;
  logic [23:0]      setup_color;
  logic [7:0]       setup_level;
  logic [7:0]       setup_arg;
  rgbfx_pkg::op_t   setup_op;

  assign pop_ready = (state == ST_IDLE);
  assign v         = rgbfx_pkg::triangle64(step[5:0]);
  assign t12       = {rgbfx_pkg::mod3_6(step[7:2]), step[1:0]};
  assign mix_sum   = acc + prod;
  assign round_sum = prod + 16'd127;
  assign lit_next  = (color != 24'd0) ? color : last_lit;

  // Classify the tick: base color, level or level factor, first operation
  always_comb begin
    setup_color = 24'd0;
    setup_level = cfg.brightness;
    setup_arg   = 8'd0;
    setup_op    = rgbfx_pkg::OP_S0;
    case (cfg.mode)
      rgbfx_pkg::MODE_BLINK: begin
        setup_color = step[0] ? 24'd0 : cfg.primary;
      end
      rgbfx_pkg::MODE_ALTERNATE: begin
        setup_color = step[0] ? cfg.secondary : cfg.primary;
      end
      rgbfx_pkg::MODE_BREATHE: begin
        setup_color = cfg.primary;
        setup_arg   = v;
        setup_op    = rgbfx_pkg::OP_LVL;
      end
      rgbfx_pkg::MODE_FADE: begin
        setup_op = rgbfx_pkg::OP_F0;
      end
      rgbfx_pkg::MODE_RAINBOW: begin
        setup_color = rgbfx_pkg::wheel({step[5:0], 2'b00});
      end
      rgbfx_pkg::MODE_PULSE: begin
        setup_color = cfg.primary;
        setup_op    = rgbfx_pkg::OP_LVL;
        case (step[3:0])
          4'd0:    setup_arg = 8'd255;
          4'd1:    setup_arg = 8'd152;
          4'd2:    setup_arg = 8'd124;
          4'd3:    setup_arg = 8'd96;
          4'd4:    setup_arg = 8'd68;
          default: setup_arg = 8'd0;
        endcase
      end
      rgbfx_pkg::MODE_HEARTBEAT: begin
        setup_color = cfg.primary;
        setup_op    = rgbfx_pkg::OP_LVL;
        case (t12)
          4'd0, 4'd2: setup_arg = 8'd255;
          4'd1, 4'd3: setup_arg = 8'd45;
          default:    setup_arg = 8'd0;
        endcase
      end
      rgbfx_pkg::MODE_SPARKLE: begin
        setup_color = (rem < rgbfx_pkg::SPARKLE_CHANCE) ? cfg.primary : 24'd0;
      end
      rgbfx_pkg::MODE_CONFETTI: begin
        setup_color = rgbfx_pkg::wheel(rnd[7:0]);
      end
      default: begin
        setup_level = 8'd0;
      end
    endcase
  end

  // Select multiplier operands and the following operation
  always_comb begin
    mul_a   = 8'd0;
    mul_b   = 8'd0;
    op_next = op;
    case (op)
      rgbfx_pkg::OP_F0: begin
        mul_a = cfg.primary[23:16];   mul_b = 8'd255 - v; op_next = rgbfx_pkg::OP_F1;
      end
      rgbfx_pkg::OP_F1: begin
        mul_a = cfg.secondary[23:16]; mul_b = v;          op_next = rgbfx_pkg::OP_F2;
      end
      rgbfx_pkg::OP_F2: begin
        mul_a = cfg.primary[15:8];    mul_b = 8'd255 - v; op_next = rgbfx_pkg::OP_F3;
      end
      rgbfx_pkg::OP_F3: begin
        mul_a = cfg.secondary[15:8];  mul_b = v;          op_next = rgbfx_pkg::OP_F4;
      end
      rgbfx_pkg::OP_F4: begin
        mul_a = cfg.primary[7:0];     mul_b = 8'd255 - v; op_next = rgbfx_pkg::OP_F5;
      end
      rgbfx_pkg::OP_F5: begin
        mul_a = cfg.secondary[7:0];   mul_b = v;          op_next = rgbfx_pkg::OP_S0;
      end
      rgbfx_pkg::OP_LVL: begin
        mul_a = cfg.brightness;       mul_b = lvl_arg;    op_next = rgbfx_pkg::OP_S0;
      end
      rgbfx_pkg::OP_S0: begin
        mul_a = color[23:16];         mul_b = level;      op_next = rgbfx_pkg::OP_S1;
      end
      rgbfx_pkg::OP_S1: begin
        mul_a = color[15:8];          mul_b = level;      op_next = rgbfx_pkg::OP_S2;
      end
      rgbfx_pkg::OP_S2: begin
        mul_a = color[7:0];           mul_b = level;      op_next = rgbfx_pkg::OP_S2;
      end
      default: begin
        op_next = rgbfx_pkg::OP_S0;
      end
    endcase
    // Hold the first scaling until the last color or level product is taken
    issue_ok = issuing &&
               !((op == rgbfx_pkg::OP_S0) && pend_valid &&
                 ((pend_op == rgbfx_pkg::OP_F5) || (pend_op == rgbfx_pkg::OP_LVL)));
  end

  // Sequencer, multiplier pipeline and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      issuing    <= 1'b0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
      last_lit   <= rgbfx_pkg::RESET_PRIMARY;
    end else begin
      // Drop the taken result unless a new one loads in this cycle
      if (out_valid && out_ready && (state != ST_WRITE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (pop_valid) begin
            step    <= pop_data.step;
            rnd     <= pop_data.noise;
            rem     <= 7'd0;
            nib_cnt <= 3'd0;
            state   <= (cfg.mode == rgbfx_pkg::MODE_SPARKLE) ? ST_REM : ST_SETUP;
          end
        end
        ST_REM: begin
          // Reduce the random word mod 100, one nibble a cycle
          rem     <= rgbfx_pkg::rem100_nibble(rem, rnd[31:28]);
          rnd     <= {rnd[27:0], 4'h0};
          nib_cnt <= nib_cnt + 3'd1;
          if (nib_cnt == 3'd7) begin
            state <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          color      <= setup_color;
          level      <= setup_level;
          lvl_arg    <= setup_arg;
          op         <= setup_op;
          issuing    <= 1'b1;
          pend_valid <= 1'b0;
          state      <= ST_MUL;
        end
        ST_MUL: begin
          if (issue_ok) begin
            prod       <= 16'(mul_a) * 16'(mul_b);
            pend_op    <= op;
            pend_valid <= 1'b1;
            op         <= op_next;
            if (op == rgbfx_pkg::OP_S2) begin
              issuing <= 1'b0;
            end
          end else begin
            pend_valid <= 1'b0;
          end
          // Take the product issued last cycle
          if (pend_valid) begin
            case (pend_op)
              rgbfx_pkg::OP_F0, rgbfx_pkg::OP_F2, rgbfx_pkg::OP_F4: acc <= prod;
              rgbfx_pkg::OP_F1:  color[23:16] <= rgbfx_pkg::div255(mix_sum);
              rgbfx_pkg::OP_F3:  color[15:8]  <= rgbfx_pkg::div255(mix_sum);
              rgbfx_pkg::OP_F5:  color[7:0]   <= rgbfx_pkg::div255(mix_sum);
              rgbfx_pkg::OP_LVL: level        <= rgbfx_pkg::div255(round_sum);
              rgbfx_pkg::OP_S0:  res_r        <= rgbfx_pkg::div255(round_sum);
              rgbfx_pkg::OP_S1:  res_g        <= rgbfx_pkg::div255(round_sum);
              rgbfx_pkg::OP_S2: begin
                res_b <= rgbfx_pkg::div255(round_sum);
                state <= ST_WRITE;
              end
              default: acc <= prod;
            endcase
          end
        end
        ST_WRITE: begin
          // Load the output register once it is free
          if (!out_valid || out_ready) begin
            result.red        <= res_r;
            result.green      <= res_g;
            result.blue       <= res_b;
            result.level      <= level;
            result.remembered <= lit_next;
            last_lit          <= lit_next;
            out_valid         <= 1'b1;
            state             <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

[design/rgb_led_effect_sequencer.sv]
`timescale 1ns / 1ps
// Top level of the RGB LED effect sequencer: configuration registers, front, queue and back.

// Each accepted item is one effect tick and yields one pixel result. The front end
// takes a tick in the cycle it arrives whenever its two-entry queue has room, advancing
// the step counter (0 to 191) and the LFSR there. The back end takes one tick at a time
// and works it out on the one 8x8 multiplier: fade mixing for fade, level scaling for
// breathe, pulse and heartbeat, then the three channel scalings in every mode; sparkle
// first reduces the random word mod 100 one nibble at a time. The finished pixel sits
// in an output register, so the next tick is worked on while a result waits.
// Configuration is written through cfg_we, cfg_index and cfg_data and should change
// only while the block is idle.
module rgb_led_effect_sequencer (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        restart,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  pixel_red,
  output logic [7:0]  pixel_green,
  output logic [7:0]  pixel_blue,
  output logic [7:0]  applied_level,
  output logic [23:0] remembered_color
);

  rgbfx_pkg::cfg_t    cfg;
  rgbfx_pkg::tick_t   push_data;
  rgbfx_pkg::tick_t   pop_data;
  rgbfx_pkg::result_t result;
  logic               push_valid;
  logic               push_ready;
  logic               pop_valid;
  logic               pop_ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode       <= rgbfx_pkg::RESET_MODE;
      cfg.primary    <= rgbfx_pkg::RESET_PRIMARY;
      cfg.secondary  <= rgbfx_pkg::RESET_SECONDARY;
      cfg.brightness <= rgbfx_pkg::RESET_BRIGHTNESS;
      cfg.seed       <= rgbfx_pkg::RESET_SEED;
    end else if (cfg_we) begin
      case (cfg_index)
        rgbfx_pkg::REG_MODE:       cfg.mode       <= cfg_data[3:0];
        rgbfx_pkg::REG_PRIMARY:    cfg.primary    <= cfg_data[23:0];
        rgbfx_pkg::REG_SECONDARY:  cfg.secondary  <= cfg_data[23:0];
        rgbfx_pkg::REG_BRIGHTNESS: cfg.brightness <= cfg_data[7:0];
        rgbfx_pkg::REG_SEED:       cfg.seed       <= cfg_data;
        default:                   cfg.mode       <= cfg.mode;
      endcase
    end
  end

  rgbfx_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .restart    (restart),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  rgbfx_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  rgbfx_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .result    (result)
  );

  assign pixel_red        = result.red;
  assign pixel_green      = result.green;
  assign pixel_blue       = result.blue;
  assign applied_level    = result.level;
  assign remembered_color = result.remembered;

  // A scaled channel never exceeds the level that scaled it
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pixel_red <= applied_level) && (pixel_green <= applied_level) &&
                  (pixel_blue <= applied_level))
    else $error("pixel channel above applied level");

  // Zero level gives a dark pixel
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && (applied_level == 8'd0)) |->
      (pixel_red == 8'd0) && (pixel_green == 8'd0) && (pixel_blue == 8'd0))
    else $error("dark level with lit pixel");

  // The remembered color is never black
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (remembered_color != 24'd0))
    else $error("remembered color is black");

endmodule

[test/tb_rgb_led_effect_sequencer.sv]
`timescale 1ns / 1ps
// Self-checking testbench of the RGB LED effect sequencer: scoreboard, drivers and checks.

// Predicts the pixel of every accepted tick and checks the results in order
class pixel_scoreboard;
  logic [3:0]  mode;
  logic [23:0] primary;
  logic [23:0] secondary;
  logic [7:0]  bright;
  logic [31:0] seed;

  logic [7:0]  step;
  logic [31:0] noise;
  logic [23:0] last_lit;

  rgbfx_pkg::result_t expected_q[$];
  int          failures;
  int          ticks;
  int          restarts;
  int          checked;
  logic [15:0] modes_seen;

  function new();
    mode       = rgbfx_pkg::RESET_MODE;
    primary    = rgbfx_pkg::RESET_PRIMARY;
    secondary  = rgbfx_pkg::RESET_SECONDARY;
    bright     = rgbfx_pkg::RESET_BRIGHTNESS;
    seed       = rgbfx_pkg::RESET_SEED;
    step       = 8'd0;
    noise      = 32'd1;
    last_lit   = rgbfx_pkg::RESET_PRIMARY;
    failures   = 0;
    ticks      = 0;
    restarts   = 0;
    checked    = 0;
    modes_seen = '0;
  endfunction

  // Mirror one register write; unknown indexes are dropped
  function void write_reg(logic [2:0] idx, logic [31:0] data);
    case (idx)
      rgbfx_pkg::REG_MODE:       mode = data[3:0];
      rgbfx_pkg::REG_PRIMARY:    primary = data[23:0];
      rgbfx_pkg::REG_SECONDARY:  secondary = data[23:0];
      rgbfx_pkg::REG_BRIGHTNESS: bright = data[7:0];
      rgbfx_pkg::REG_SEED:       seed = data;
      default: ;
    endcase
  endfunction

  // Rounded c * lvl / 255
  function logic [7:0] shade(logic [7:0] c, logic [7:0] lvl);
    int unsigned prod;
    prod = int'(c) * int'(lvl) + 127;
    return 8'(prod / 255);
  endfunction

  // Triangle over 64 steps: up by 8 for 32 steps, then back down
  function logic [7:0] ramp64(logic [7:0] s);
    int unsigned t;
    t = s % 64;
    return 8'((t < 32) ? t * 8 : (63 - t) * 8);
  endfunction

  function logic [23:0] hue_wheel(logic [7:0] x);
    int unsigned w;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    w = 255 - x;
    if (w < 85) begin
      r = 8'(255 - 3 * w);
      g = 8'd0;
      b = 8'(3 * w);
    end else if (w < 170) begin
      w = w - 85;
      r = 8'd0;
      g = 8'(3 * w);
      b = 8'(255 - 3 * w);
    end else begin
      w = w - 170;
      r = 8'(3 * w);
      g = 8'(255 - 3 * w);
      b = 8'd0;
    end
    return {r, g, b};
  endfunction

  // Advance the Galois noise register by one shift
  function void noise_advance();
    if (noise[0]) begin
      noise = (noise >> 1) ^ rgbfx_pkg::LFSR_TAPS;
    end else begin
      noise = noise >> 1;
    end
  endfunction

  // Work out the pixel of one accepted tick and queue it
  function void note_input(bit rs);
    logic [23:0] color;
    logic [7:0]  level;
    logic [7:0]  v;
    logic [7:0]  ch[3];
    int unsigned t;
    int unsigned p;
    int unsigned q;
    rgbfx_pkg::result_t r;
    ticks++;
    if (rs) begin
      restarts++;
      step  = 8'd0;
      noise = (seed != 32'd0) ? seed : 32'd1;
    end
    color = 24'd0;
    level = 8'd0;
    case (mode)
      rgbfx_pkg::MODE_BLINK: begin
        color = step[0] ? 24'd0 : primary;
        level = bright;
      end
      rgbfx_pkg::MODE_ALTERNATE: begin
        color = step[0] ? secondary : primary;
        level = bright;
      end
      rgbfx_pkg::MODE_BREATHE: begin
        color = primary;
        level = shade(bright, ramp64(step));
      end
      rgbfx_pkg::MODE_FADE: begin
        v = ramp64(step);
        for (int k = 0; k < 3; k++) begin
          p = primary[(2 - k) * 8 +: 8];
          q = secondary[(2 - k) * 8 +: 8];
          ch[k] = 8'((p * (255 - v) + q * v) / 255);
        end
        color = {ch[0], ch[1], ch[2]};
        level = bright;
      end
      rgbfx_pkg::MODE_RAINBOW: begin
        color = hue_wheel({step[5:0], 2'b00});
        level = bright;
      end
      rgbfx_pkg::MODE_PULSE: begin
        t = step % 16;
        color = primary;
        if (t == 0) begin
          level = bright;
        end else if (t < 5) begin
          level = shade(bright, 8'(180 - 28 * t));
        end
      end
      rgbfx_pkg::MODE_HEARTBEAT: begin
        t = step % 12;
        color = primary;
        if (t == 0 || t == 2) begin
          level = bright;
        end else if (t == 1 || t == 3) begin
          level = shade(bright, 8'd45);
        end
      end
      rgbfx_pkg::MODE_SPARKLE: begin
        noise_advance();
        color = ((noise % 100) < rgbfx_pkg::SPARKLE_CHANCE) ? primary : 24'd0;
        level = bright;
      end
      rgbfx_pkg::MODE_CONFETTI: begin
        noise_advance();
        color = hue_wheel(noise[7:0]);
        level = bright;
      end
      default: ;
    endcase
    // Black keeps the remembered color
    if (color != 24'd0) begin
      last_lit = color;
    end
    r.red        = shade(color[23:16], level);
    r.green      = shade(color[15:8], level);
    r.blue       = shade(color[7:0], level);
    r.level      = level;
    r.remembered = last_lit;
    expected_q.push_back(r);
    modes_seen[mode] = 1'b1;
    step = (step == rgbfx_pkg::STEP_LAST) ? 8'd0 : step + 8'd1;
  endfunction

  function void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      failures++;
    end
  endfunction

  // Compare one accepted pixel item with the oldest prediction
  function void check_result(rgbfx_pkg::result_t got);
    rgbfx_pkg::result_t want;
    if (expected_q.size() == 0) begin
      $error("pixel item with no tick waiting: %0h", got);
      failures++;
      return;
    end
    want = expected_q.pop_front();
    checked++;
    check_field("pixel_red", want.red, got.red);
    check_field("pixel_green", want.green, got.green);
    check_field("pixel_blue", want.blue, got.blue);
    check_field("applied_level", want.level, got.level);
    check_field("remembered_color", want.remembered, got.remembered);
  endfunction

  function int pending();
    return expected_q.size();
  endfunction
endclass

module tb_rgb_led_effect_sequencer;
  localparam int CLK_HALF       = 10;
  localparam int RESET_CYCLES   = 7;
  localparam int RANDOM_ITEMS   = 1800;
  localparam int LONG_HOLD      = 300;
  localparam int SETTLE         = 24;
  localparam int WATCHDOG_LIMIT = 3000;

  localparam logic [3:0] MODE_UNUSED_LAST = 4'd15;
  localparam logic [2:0] REG_UNUSED       = 3'd7;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = 3'd0;
  logic [31:0] cfg_data = 32'd0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        restart = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  pixel_red;
  logic [7:0]  pixel_green;
  logic [7:0]  pixel_blue;
  logic [7:0]  applied_level;
  logic [23:0] remembered_color;

  pixel_scoreboard board;

  int hold_req = 0;
  int hold_done = 0;
  int hold_left = 0;
  int rx_cycle = 0;
  int rx_style = 0;
  int idle_cycles = 0;
  int settings_used = 0;
  int sent = 0;

  rgb_led_effect_sequencer DUT (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .restart          (restart),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .pixel_red        (pixel_red),
    .pixel_green      (pixel_green),
    .pixel_blue       (pixel_blue),
    .applied_level    (applied_level),
    .remembered_color (remembered_color)
  );

  always begin
    #(CLK_HALF) clk = 1'b1;
    #(CLK_HALF) clk = 1'b0;
  end

  // Hold one register write for a cycle; the caller drops the write enable
  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    board.write_reg(idx, data);
  endtask

  // Write every register, with junk in the unused upper bits
  task automatic apply_settings(logic [3:0] m, logic [23:0] p, logic [23:0] s,
                                logic [7:0] b, logic [31:0] sd);
    logic [31:0] junk;
    junk = $urandom;
    write_reg(rgbfx_pkg::REG_MODE, {junk[31:4], m});
    junk = $urandom;
    write_reg(rgbfx_pkg::REG_PRIMARY, {junk[31:24], p});
    junk = $urandom;
    write_reg(rgbfx_pkg::REG_SECONDARY, {junk[31:24], s});
    junk = $urandom;
    write_reg(rgbfx_pkg::REG_BRIGHTNESS, {junk[31:8], b});
    write_reg(rgbfx_pkg::REG_SEED, sd);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // Offer one tick and hold it until accepted
  task automatic send_item(bit rs);
    in_valid <= 1'b1;
    restart  <= rs;
    do @(posedge clk); while (!in_ready);
    board.note_input(rs);
    sent++;
  endtask

  // Send ticks in bursts with random gaps between them
  task automatic send_items(int n, int restart_pct, int gap_max);
    int burst;
    burst = $urandom_range(1, 16);
    for (int i = 0; i < n; i++) begin
      send_item($urandom_range(0, 99) < restart_pct);
      burst--;
      if (burst == 0 && gap_max > 0 && i < n - 1) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, gap_max)) @(posedge clk);
        burst = $urandom_range(1, 16);
      end
    end
  endtask

  // Stop offering and wait until every predicted pixel has come back
  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Receiver: honor long hold requests, otherwise stall on a changing pattern
  always @(posedge clk) begin
    rx_cycle++;
    if (hold_req != hold_done) begin
      hold_done = hold_req;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      if (rx_cycle % 200 == 0) begin
        rx_style = $urandom_range(0, 3);
      end
      case (rx_style)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        2: out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  // Check every accepted pixel item
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      board.check_result({pixel_red, pixel_green, pixel_blue, applied_level,
                          remembered_color});
    end
  end

  // End the run if nothing moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
      $display("rgb_led_effect_sequencer: mismatch");
      $finish;
    end
  end

  initial begin
    logic [3:0]  m;
    logic [23:0] p;
    logic [23:0] s;
    logic [7:0]  b;
    logic [31:0] sd;
    int          n;
    int          pct;
    int          gap;
    int          random_start;
    bit          pressure_done;
    board = new();
    pressure_done = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: breathe in the reset color
    send_item(1'b0);
    send_item(1'b0);
    drain();

    // Blink at full level: lit on even steps, black on odd keeps the memory
    apply_settings(rgbfx_pkg::MODE_BLINK, 24'hFFFFFF, 24'h000000, 8'hFF, 32'd1);
    send_item(1'b1);
    send_item(1'b0);
    drain();

    // Alternate from black to white
    apply_settings(rgbfx_pkg::MODE_ALTERNATE, 24'h000000, 24'hFFFFFF, 8'hFF, 32'd1);
    send_item(1'b1);
    send_item(1'b0);
    drain();

    // Zero brightness
    apply_settings(rgbfx_pkg::MODE_BREATHE, 24'hFFFFFF, 24'h000000, 8'h00, 32'd1);
    send_item(1'b0);
    drain();

    apply_settings(rgbfx_pkg::MODE_FADE, 24'hFF00FF, 24'h00FF00, 8'hFF, 32'd1);
    send_item(1'b1);
    send_item(1'b0);
    drain();

    apply_settings(rgbfx_pkg::MODE_RAINBOW, 24'h000000, 24'h000000, 8'hFF, 32'd1);
    send_item(1'b0);
    send_item(1'b0);
    drain();

    apply_settings(rgbfx_pkg::MODE_PULSE, 24'h123456, 24'h000000, 8'hFF, 32'd1);
    send_item(1'b1);
    send_item(1'b0);
    drain();

    apply_settings(rgbfx_pkg::MODE_HEARTBEAT, 24'hABCDEF, 24'h000000, 8'hC8, 32'd1);
    send_item(1'b1);
    send_item(1'b0);
    drain();

    // Zero seed must load the noise register with one
    apply_settings(rgbfx_pkg::MODE_SPARKLE, 24'hFFFFFF, 24'h000000, 8'hFF, 32'd0);
    send_item(1'b1);
    send_item(1'b0);
    send_item(1'b0);
    drain();

    apply_settings(rgbfx_pkg::MODE_CONFETTI, 24'h000000, 24'h000000, 8'hFF, 32'hFFFFFFFF);
    send_item(1'b1);
    send_item(1'b0);
    drain();

    // Unused register index and unused mode
    write_reg(REG_UNUSED, $urandom);
    apply_settings(MODE_UNUSED_LAST, 24'hFFFFFF, 24'hFFFFFF, 8'hFF, 32'd1);
    send_item(1'b0);
    send_item(1'b0);
    drain();

    // Random phases, each with fresh settings and its own traffic shape
    random_start = sent;
    while (sent - random_start < RANDOM_ITEMS) begin
      if ($urandom_range(0, 99) < 85) begin
        m = 4'($urandom_range(rgbfx_pkg::MODE_BLINK, rgbfx_pkg::MODE_CONFETTI));
      end else begin
        m = 4'($urandom_range(rgbfx_pkg::MODE_CONFETTI + 1, MODE_UNUSED_LAST));
      end
      case ($urandom_range(0, 5))
        0: p = 24'h000000;
        1: p = 24'hFFFFFF;
        default: p = 24'($urandom);
      endcase
      case ($urandom_range(0, 5))
        0: s = 24'h000000;
        1: s = 24'hFFFFFF;
        default: s = 24'($urandom);
      endcase
      case ($urandom_range(0, 5))
        0: b = 8'h00;
        1: b = 8'hFF;
        default: b = 8'($urandom);
      endcase
      case ($urandom_range(0, 7))
        0: sd = 32'd0;
        1: sd = 32'hFFFFFFFF;
        default: sd = $urandom;
      endcase
      apply_settings(m, p, s, b, sd);
      n = $urandom_range(20, 100);
      case ($urandom_range(0, 3))
        0, 1: pct = 0;
        2: pct = 3;
        default: pct = 20;
      endcase
      case ($urandom_range(0, 2))
        0: gap = 0;
        1: gap = 4;
        default: gap = 24;
      endcase
      // Once, stall the receiver for a long stretch so the input backs up
      if (!pressure_done) begin
        pressure_done = 1'b1;
        hold_req++;
        n = 40;
        gap = 0;
      end
      send_items(n, pct, gap);
      drain();
    end

    $display("covered %0d ticks (%0d restarts) over %0d register settings, modes seen %b",
             board.ticks, board.restarts, settings_used, board.modes_seen);
    $display("checked %0d pixel items, %0d mismatching fields", board.checked, board.failures);
    if (board.failures == 0 && board.pending() == 0) begin
      $display("rgb_led_effect_sequencer: match");
    end else begin
      $display("rgb_led_effect_sequencer: mismatch");
    end
    $finish;
  end
endmodule
